[rtl/ied_pkg.sv]
// ----------------------------------------------------------------------------
// ied_pkg
// Shared widths and stage types for the integer euclidean distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package ied_pkg;

   // coordinate width of each input field
   localparam int COORD_W = 16;
   // width of one squared difference
   localparam int SQ_W    = 2 * COORD_W;
   // width of the root, one cell per root bit
   localparam int RES_W   = COORD_W + 1;
   // sum of three squares, two radicand bits per root bit
   localparam int SUM_W   = 2 * RES_W;
   // partial remainder width, never above twice the partial root plus one pair
   localparam int REM_W   = RES_W + 2;

   // working set handed from cell to cell
   typedef struct packed {
      logic [SUM_W-1:0] rad;
      logic [RES_W-1:0] root;
      logic [REM_W-1:0] rem;
   } root_type;

   // one pipeline stage: valid flag plus working set
   typedef struct packed {
      logic     valid;
      root_type data;
   } stage_type;

endpackage

`default_nettype wire

[rtl/ied_diff_square.sv]
// ----------------------------------------------------------------------------
// ied_diff_square
// Front end: coordinate differences, squares and full-width sum of squares,
// three register stages with per-stage flow control.
// ----------------------------------------------------------------------------
`default_nettype none

module ied_diff_square (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               in_valid,
   output logic                                    in_ready,
   input  wire logic signed [ied_pkg::COORD_W-1:0] ax,
   input  wire logic signed [ied_pkg::COORD_W-1:0] ay,
   input  wire logic signed [ied_pkg::COORD_W-1:0] az,
   input  wire logic signed [ied_pkg::COORD_W-1:0] bx,
   input  wire logic signed [ied_pkg::COORD_W-1:0] by_coord,
   input  wire logic signed [ied_pkg::COORD_W-1:0] bz,
   output ied_pkg::stage_type                      out_stage,
   input  wire logic                               out_ready
);
   import ied_pkg::*;

   logic               mag_valid_ff, sq_valid_ff, sum_valid_ff;
   logic [COORD_W-1:0] mag_x_ff, mag_y_ff, mag_z_ff;
   logic [COORD_W-1:0] mag_x_in, mag_y_in, mag_z_in;
   logic [SQ_W-1:0]    sq_x_ff, sq_y_ff, sq_z_ff;
   logic [SQ_W-1:0]    sq_x_in, sq_y_in, sq_z_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               rdy_mag, rdy_sq, rdy_sum;

   // magnitude of a signed difference, fits the coordinate width
   function automatic logic [COORD_W-1:0] diff_mag(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      logic [COORD_W:0] d;
      logic [COORD_W:0] m;
      d = {b[COORD_W-1], b} - {a[COORD_W-1], a};
      m = d[COORD_W] ? (~d + 1'b1) : d;
      return m[COORD_W-1:0];
   endfunction

   // stage ready chain, a stage moves when it is empty or its successor moves
   assign rdy_sum  = !sum_valid_ff || out_ready;
   assign rdy_sq   = !sq_valid_ff  || rdy_sum;
   assign rdy_mag  = !mag_valid_ff || rdy_sq;
   assign in_ready = rdy_mag;

   // differences
   always_comb begin
      mag_x_in = diff_mag(ax, bx);
      mag_y_in = diff_mag(ay, by_coord);
      mag_z_in = diff_mag(az, bz);
   end

   // squares, one multiplier per axis
   always_comb begin
      sq_x_in = SQ_W'(mag_x_ff) * SQ_W'(mag_x_ff);
      sq_y_in = SQ_W'(mag_y_ff) * SQ_W'(mag_y_ff);
      sq_z_in = SQ_W'(mag_z_ff) * SQ_W'(mag_z_ff);
   end

   // full-width sum, no wrap
   assign sum_in = SUM_W'(sq_x_ff) + SUM_W'(sq_y_ff) + SUM_W'(sq_z_ff);

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         mag_valid_ff <= 1'b0;
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         if (rdy_mag) mag_valid_ff <= in_valid;
         if (rdy_sq)  sq_valid_ff  <= mag_valid_ff;
         if (rdy_sum) sum_valid_ff <= sq_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (rdy_mag && in_valid) begin
         mag_x_ff <= mag_x_in;
         mag_y_ff <= mag_y_in;
         mag_z_ff <= mag_z_in;
      end
      if (rdy_sq && mag_valid_ff) begin
         sq_x_ff <= sq_x_in;
         sq_y_ff <= sq_y_in;
         sq_z_ff <= sq_z_in;
      end
      if (rdy_sum && sq_valid_ff) begin
         sum_ff <= sum_in;
      end
   end

   // seed of the root chain
   always_comb begin
      out_stage.valid     = sum_valid_ff;
      out_stage.data.rad  = sum_ff;
      out_stage.data.root = '0;
      out_stage.data.rem  = '0;
   end

endmodule

`default_nettype wire

[rtl/ied_root_cell.sv]
// ----------------------------------------------------------------------------
// ied_root_cell
// One restoring square-root step: brings in the next radicand pair and
// decides one root bit, then hands the working set to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module ied_root_cell (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire ied_pkg::stage_type in_stage,
   output logic        in_ready,
   output ied_pkg::stage_type out_stage,
   input  wire logic   out_ready
);
   import ied_pkg::*;

   logic       valid_ff;
   root_type   data_ff, data_in;
   logic [REM_W-1:0] rem_shift, trial;
   logic       take;

   assign in_ready = !valid_ff || out_ready;

   // one compare and subtract step
   always_comb begin
      rem_shift    = {in_stage.data.rem[REM_W-3:0], in_stage.data.rad[SUM_W-1:SUM_W-2]};
      trial        = {in_stage.data.root, 2'b01};
      take         = (rem_shift >= trial);
      data_in.rem  = take ? (rem_shift - trial) : rem_shift;
      data_in.root = {in_stage.data.root[RES_W-2:0], take};
      data_in.rad  = {in_stage.data.rad[SUM_W-3:0], 2'b00};
   end

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_stage.valid;
      end
   end

   // working set
   always_ff @(posedge clock) begin
      if (in_ready && in_stage.valid) begin
         data_ff <= data_in;
      end
   end

   assign out_stage.valid = valid_ff;
   assign out_stage.data  = data_ff;

   // remainder never exceeds twice the partial root
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (data_ff.rem <= {1'b0, data_ff.root, 1'b0}))
      else $error("root cell remainder out of bound");

   // a held working set does not change
   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(data_ff))
      else $error("root cell lost a stalled transaction");

endmodule

`default_nettype wire

[rtl/integer_euclidean_distance.sv]
// ----------------------------------------------------------------------------
// integer_euclidean_distance
// Floor of the euclidean distance between two signed 3-D points: squared
// differences summed at full width, then a chain of restoring root cells.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_ax..req_bz, 16-bit signed
//   rsp     | out       | rsp_valid/rsp_stall | rsp_dist_res, 17-bit unsigned
//
// one transaction per cycle while rsp_stall is low, every stage holds its own
// transaction; 3 front stages, 17 root cells (one per root bit), 1 output
// stalls ripple back only through full stages, bubbles are squeezed out
// reset clears all valid flags, payload registers are not reset
// ----------------------------------------------------------------------------
`default_nettype none

module integer_euclidean_distance (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic signed [ied_pkg::COORD_W-1:0] req_ax,
   input  wire logic signed [ied_pkg::COORD_W-1:0] req_ay,
   input  wire logic signed [ied_pkg::COORD_W-1:0] req_az,
   input  wire logic signed [ied_pkg::COORD_W-1:0] req_bx,
   input  wire logic signed [ied_pkg::COORD_W-1:0] req_by_coord,
   input  wire logic signed [ied_pkg::COORD_W-1:0] req_bz,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [ied_pkg::RES_W-1:0]               rsp_dist_res
);
   import ied_pkg::*;

   stage_type        chain [0:RES_W];
   logic             chain_ready [0:RES_W];
   logic             front_ready;
   logic             rsp_valid_ff;
   logic [RES_W-1:0] rsp_dist_res_ff;

   // front end
   ied_diff_square u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .ax        (req_ax),
      .ay        (req_ay),
      .az        (req_az),
      .bx        (req_bx),
      .by_coord  (req_by_coord),
      .bz        (req_bz),
      .out_stage (chain[0]),
      .out_ready (chain_ready[0])
   );

   assign req_stall = !front_ready;

   // root cell chain, one root bit per cell
   for (genvar i = 0; i < RES_W; i++) begin : g_cell
      ied_root_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_stage  (chain[i]),
         .in_ready  (chain_ready[i]),
         .out_stage (chain[i+1]),
         .out_ready (chain_ready[i+1])
      );
   end

   // output register
   assign chain_ready[RES_W] = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (chain_ready[RES_W]) begin
         rsp_valid_ff <= chain[RES_W].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (chain_ready[RES_W] && chain[RES_W].valid) begin
         rsp_dist_res_ff <= chain[RES_W].data.root;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_dist_res = rsp_dist_res_ff;

   // no transaction survives reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid right after reset");

endmodule

`default_nettype wire
